// ===== rtl/self_avoiding_walk_step_macros.svh =====
// Assertion macros shared by the walk-step RTL.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef SELF_AVOIDING_WALK_STEP_MACROS_SVH
`define SELF_AVOIDING_WALK_STEP_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define SAW_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Same-cycle implication
`define SAW_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SAW_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/saw_pkg.sv =====
// Shared codes, field widths and reset values for the walk-step block.
// Used by self_avoiding_walk_step; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package saw_pkg;

   // field widths
   localparam int DIR_W     = 2;
   localparam int OUTCOME_W = 3;
   localparam int LEN_W     = 14;
   localparam int POS_OUT_W = 7;
   localparam int TALLY_W   = 32;
   localparam int SUM_W     = 48;
   localparam int TRIALS_W  = 20;
   localparam int GRID_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 20;

   // visited-map entries carry a trial mark this wide; zero is never a live mark
   localparam int EPOCH_W = 8;

   // result outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_MOVED    = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_BLOCKED  = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_ESCAPED  = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_DEAD_END = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_FINISHED = 3'd4;

   // direction codes (also used to walk the four neighbors)
   localparam logic [DIR_W-1:0] DIR_PLUS_X  = 2'd0;
   localparam logic [DIR_W-1:0] DIR_MINUS_X = 2'd1;
   localparam logic [DIR_W-1:0] DIR_PLUS_Y  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_MINUS_Y = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIZE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIAL_LIMIT = 1'b1;

   // register reset values
   localparam logic [GRID_W-1:0]   GRID_RESET  = 7'd50;
   localparam logic [TRIALS_W-1:0] LIMIT_RESET = 20'd1000;

endpackage

`default_nettype wire

// ===== rtl/self_avoiding_walk_step.sv =====
// Self-avoiding random walk step engine: top level.
// Depends on saw_pkg, saw_ram and self_avoiding_walk_step_macros.svh.
//
// Usage: each req_ item carries one random direction; each item gives exactly
// one rsp_ item with the outcome, the recorded walk length, the walker position
// and the running trial statistics. Registers are written through csr_ (index 0
// grid size, index 1 trial limit) while no item is in flight.
// From accept to result: an item goes straight to commit when the trial limit is
// reached, through the target check for a blocked move or an escape, and on
// through one map read per neighbor until an unvisited one is found for a move
// that stays inside. All map lookups share the single read port of the visited
// map; an item that ends a trial then passes a step that marks the new centre.
// Items are taken one at a time; req_stall is high while an item is in work.
// The result sits in an output register, so a stalled receiver only holds the
// engine at its commit step; the next item may be accepted while a result waits.
// Reset (synchronous) restores the registers and statistics and starts a
// clearing pass over all MAX_GRID*MAX_GRID cells of the map; the same pass runs
// after every 255th trial end, when the trial mark wraps. No item is accepted
// during the pass; register writes are taken as ever.
`timescale 1ns / 1ps
`default_nettype none

`include "self_avoiding_walk_step_macros.svh"

module self_avoiding_walk_step #(
   parameter int MAX_GRID = 128
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input items
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [saw_pkg::DIR_W-1:0]          req_direction,
   // result items
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [saw_pkg::OUTCOME_W-1:0]      rsp_outcome,
   output logic      [saw_pkg::LEN_W-1:0]          rsp_step_count,
   output logic      [saw_pkg::POS_OUT_W-1:0]      rsp_walker_x,
   output logic      [saw_pkg::POS_OUT_W-1:0]      rsp_walker_y,
   output logic      [saw_pkg::TALLY_W-1:0]        rsp_escapes,
   output logic      [saw_pkg::TALLY_W-1:0]        rsp_dead_ends,
   output logic      [saw_pkg::SUM_W-1:0]          rsp_escape_length_total,
   output logic      [saw_pkg::SUM_W-1:0]          rsp_dead_end_length_total,
   output logic      [saw_pkg::TRIALS_W-1:0]       rsp_trials_done,
   // configuration writes
   input  wire logic                               csr_wr_en,
   input  wire logic [saw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [saw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW    = $clog2(MAX_GRID);
   localparam int DEPTH = MAX_GRID * MAX_GRID;
   localparam int AW    = $clog2(DEPTH);
   localparam int EW    = saw_pkg::EPOCH_W;
   localparam int LW    = saw_pkg::LEN_W;
   localparam int TW    = saw_pkg::TALLY_W;
   localparam int SW    = saw_pkg::SUM_W;
   localparam int RW    = saw_pkg::TRIALS_W;
   localparam int GW    = saw_pkg::GRID_W;
   localparam int OW    = saw_pkg::OUTCOME_W;
   localparam int PW    = saw_pkg::POS_OUT_W;

   localparam logic [CW+GW:0] N_MIN = (CW+GW+1)'(2);
   localparam logic [CW+GW:0] N_MAX = (CW+GW+1)'(MAX_GRID - 2);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;  // sweep the map
   localparam logic [2:0] S_IDLE  = 3'd1;  // wait for an item, read target
   localparam logic [2:0] S_TGT   = 3'd2;  // target data back, mark it
   localparam logic [2:0] S_NBR   = 3'd3;  // neighbor data back
   localparam logic [2:0] S_FIN   = 3'd4;  // commit and load the result
   localparam logic [2:0] S_CTR   = 3'd5;  // mark the new centre

   // clamp the grid size register into the usable range
   function automatic logic [CW-1:0] eff_n(input logic [GW-1:0] grid);
      logic [CW+GW:0] g;
      g = {(CW+1)'(0), grid};
      if (g < N_MIN) begin
         g = N_MIN;
      end else if (g > N_MAX) begin
         g = N_MAX;
      end
      return g[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] centre_of(input logic [CW-1:0] n);
      logic [CW:0] s;
      s = {1'b0, n} + (CW+1)'(1);
      return s[CW:1];
   endfunction

   function automatic logic [CW-1:0] step_x(input logic [CW-1:0] x,
                                            input logic [saw_pkg::DIR_W-1:0] d);
      logic [CW-1:0] r;
      r = x;
      if (d == saw_pkg::DIR_PLUS_X) begin
         r = x + CW'(1);
      end else if (d == saw_pkg::DIR_MINUS_X) begin
         r = x - CW'(1);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] step_y(input logic [CW-1:0] y,
                                            input logic [saw_pkg::DIR_W-1:0] d);
      logic [CW-1:0] r;
      r = y;
      if (d == saw_pkg::DIR_PLUS_Y) begin
         r = y + CW'(1);
      end else if (d == saw_pkg::DIR_MINUS_Y) begin
         r = y - CW'(1);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
      return AW'(x * MAX_GRID + y);
   endfunction

   function automatic logic [PW-1:0] pos_out(input logic [CW-1:0] x);
      logic [CW+PW-1:0] t;
      t = {PW'(0), x};
      return t[PW-1:0];
   endfunction

   function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                             input logic [LW-1:0] a);
      logic [SW:0] r;
      r = {1'b0, s} + (SW+1)'(a);
      return r[SW] ? '1 : r[SW-1:0];
   endfunction

   function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
      return (v == '1) ? v : v + TW'(1);
   endfunction

   localparam logic [CW-1:0] RESET_CENTRE = centre_of(eff_n(saw_pkg::GRID_RESET));

   // control and walker state
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [EW-1:0] epoch_ff, epoch_in;
   logic [CW-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [CW-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [1:0]    nbr_ff, nbr_in;
   logic [OW-1:0] kind_ff, kind_in;
   logic [LW-1:0] walk_len_ff, walk_len_in;
   logic [TW-1:0] esc_tally_ff, esc_tally_in, dead_tally_ff, dead_tally_in;
   logic [SW-1:0] esc_sum_ff, esc_sum_in, dead_sum_ff, dead_sum_in;
   logic [RW-1:0] trial_tally_ff, trial_tally_in;
   logic [GW-1:0] grid_ff, grid_in;
   logic [RW-1:0] limit_ff, limit_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_outcome_ff, rsp_outcome_in;
   logic [LW-1:0] rsp_step_count_ff, rsp_step_count_in;
   logic [CW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // map port
   logic          ram_rd_en, ram_wr_en;
   logic [AW-1:0] ram_rd_addr, ram_wr_addr;
   logic [EW-1:0] ram_rd_data, ram_wr_data;

   // datapath helpers
   logic          req_take, limit_hit, cell_seen, escape_hit, out_free;
   logic          fin_commit, trial_end;
   logic [CW-1:0] n_cur, centre_cur, step_tx, step_ty, rd_x, rd_y, wr_x, wr_y;
   logic [1:0]    nbr_sel;
   logic [AW-1:0] wr_cell;
   logic [LW-1:0] len_inc, report;

   // visited map: one trial mark per cell
   saw_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign limit_hit  = (trial_tally_ff >= limit_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fin_commit = (state_ff == S_FIN) && out_free;
   assign trial_end  = (kind_ff == saw_pkg::OUT_ESCAPED) ||
                       (kind_ff == saw_pkg::OUT_DEAD_END);
   assign n_cur      = eff_n(grid_ff);
   assign centre_cur = centre_of(n_cur);
   assign cell_seen  = (ram_rd_data == epoch_ff);
   assign escape_hit = (tgt_x_ff > n_cur) || (tgt_y_ff > n_cur) ||
                       (tgt_x_ff == '0) || (tgt_y_ff == '0);
   assign len_inc    = (walk_len_ff == '1) ? walk_len_ff : walk_len_ff + LW'(1);

   // proposed target from the current position
   assign step_tx = step_x(pos_x_ff, req_direction);
   assign step_ty = step_y(pos_y_ff, req_direction);

   // read address: target in idle, then the neighbors of the target in order.
   // Reads never hit the cell written in the same cycle, so no forwarding.
   assign nbr_sel     = (state_ff == S_TGT) ? 2'd0 : nbr_ff + 2'd1;
   assign rd_x        = (state_ff == S_IDLE) ? step_tx : step_x(tgt_x_ff, nbr_sel);
   assign rd_y        = (state_ff == S_IDLE) ? step_ty : step_y(tgt_y_ff, nbr_sel);
   assign ram_rd_addr = cell_addr(rd_x, rd_y);
   assign ram_rd_en   = (state_ff == S_IDLE) || (state_ff == S_TGT) || (state_ff == S_NBR);

   // write port: mark the target, mark the centre, or sweep
   assign wr_x    = (state_ff == S_TGT) ? tgt_x_ff : pos_x_ff;
   assign wr_y    = (state_ff == S_TGT) ? tgt_y_ff : pos_y_ff;
   assign wr_cell = cell_addr(wr_x, wr_y);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_cell;
      ram_wr_data = epoch_ff;
      if (state_ff == S_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = (clr_addr_ff == wr_cell) ? epoch_ff : '0;
      end else if (state_ff == S_CTR) begin
         ram_wr_en = 1'b1;
      end else if ((state_ff == S_TGT) && !cell_seen) begin
         ram_wr_en = 1'b1;
      end
   end

   // recorded length of the item being committed
   always_comb begin
      unique case (kind_ff)
         saw_pkg::OUT_MOVED, saw_pkg::OUT_ESCAPED: report = len_inc;
         saw_pkg::OUT_DEAD_END:                    report = len_inc - LW'(1);
         default:                                  report = walk_len_ff;
      endcase
   end

   // sequencer and state update
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      epoch_in       = epoch_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      tgt_x_in       = tgt_x_ff;
      tgt_y_in       = tgt_y_ff;
      nbr_in         = nbr_ff;
      kind_in        = kind_ff;
      walk_len_in    = walk_len_ff;
      esc_tally_in   = esc_tally_ff;
      dead_tally_in  = dead_tally_ff;
      esc_sum_in     = esc_sum_ff;
      dead_sum_in    = dead_sum_ff;
      trial_tally_in = trial_tally_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               clr_addr_in = '0;
               state_in    = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               tgt_x_in = step_tx;
               tgt_y_in = step_ty;
               if (limit_hit) begin
                  kind_in  = saw_pkg::OUT_FINISHED;
                  state_in = S_FIN;
               end else begin
                  state_in = S_TGT;
               end
            end
         end
         S_TGT: begin
            nbr_in = 2'd0;
            if (cell_seen) begin
               kind_in  = saw_pkg::OUT_BLOCKED;
               state_in = S_FIN;
            end else if (escape_hit) begin
               kind_in  = saw_pkg::OUT_ESCAPED;
               state_in = S_FIN;
            end else begin
               state_in = S_NBR;
            end
         end
         S_NBR: begin
            // stop at the first free neighbor
            if (!cell_seen) begin
               kind_in  = saw_pkg::OUT_MOVED;
               state_in = S_FIN;
            end else if (nbr_ff == 2'd3) begin
               kind_in  = saw_pkg::OUT_DEAD_END;
               state_in = S_FIN;
            end else begin
               nbr_in = nbr_ff + 2'd1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
               unique case (kind_ff)
                  saw_pkg::OUT_MOVED: begin
                     pos_x_in    = tgt_x_ff;
                     pos_y_in    = tgt_y_ff;
                     walk_len_in = len_inc;
                  end
                  saw_pkg::OUT_ESCAPED: begin
                     esc_tally_in = sat_inc(esc_tally_ff);
                     esc_sum_in   = sat_add(esc_sum_ff, report);
                  end
                  saw_pkg::OUT_DEAD_END: begin
                     dead_tally_in = sat_inc(dead_tally_ff);
                     dead_sum_in   = sat_add(dead_sum_ff, report);
                  end
                  default: begin
                  end
               endcase
               // new trial: back to the centre under a fresh mark
               if (trial_end) begin
                  trial_tally_in = trial_tally_ff + RW'(1);
                  pos_x_in       = centre_cur;
                  pos_y_in       = centre_cur;
                  walk_len_in    = '0;
                  if (epoch_ff == '1) begin
                     epoch_in    = EW'(1);
                     clr_addr_in = '0;
                     state_in    = S_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + EW'(1);
                     state_in = S_CTR;
                  end
               end
            end
         end
         S_CTR: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      grid_in  = grid_ff;
      limit_in = limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            saw_pkg::REG_GRID_SIZE:   grid_in  = csr_wdata[GW-1:0];
            saw_pkg::REG_TRIAL_LIMIT: limit_in = csr_wdata[RW-1:0];
         endcase
      end
   end

   // result register: load at commit, drop when taken
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_outcome_in    = rsp_outcome_ff;
      rsp_step_count_in = rsp_step_count_ff;
      rsp_x_in          = rsp_x_ff;
      rsp_y_in          = rsp_y_ff;
      if (fin_commit) begin
         rsp_valid_in      = 1'b1;
         rsp_outcome_in    = kind_ff;
         rsp_step_count_in = report;
         rsp_x_in          = pos_x_in;
         rsp_y_in          = pos_y_in;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_addr_ff    <= '0;
         epoch_ff       <= EW'(1);
         pos_x_ff       <= RESET_CENTRE;
         pos_y_ff       <= RESET_CENTRE;
         walk_len_ff    <= '0;
         esc_tally_ff   <= '0;
         dead_tally_ff  <= '0;
         esc_sum_ff     <= '0;
         dead_sum_ff    <= '0;
         trial_tally_ff <= '0;
         grid_ff        <= saw_pkg::GRID_RESET;
         limit_ff       <= saw_pkg::LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         epoch_ff       <= epoch_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         walk_len_ff    <= walk_len_in;
         esc_tally_ff   <= esc_tally_in;
         dead_tally_ff  <= dead_tally_in;
         esc_sum_ff     <= esc_sum_in;
         dead_sum_ff    <= dead_sum_in;
         trial_tally_ff <= trial_tally_in;
         grid_ff        <= grid_in;
         limit_ff       <= limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tgt_x_ff          <= tgt_x_in;
      tgt_y_ff          <= tgt_y_in;
      nbr_ff            <= nbr_in;
      kind_ff           <= kind_in;
      rsp_outcome_ff    <= rsp_outcome_in;
      rsp_step_count_ff <= rsp_step_count_in;
      rsp_x_ff          <= rsp_x_in;
      rsp_y_ff          <= rsp_y_in;
   end

   // statistics reflect the state after the last committed item
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_outcome               = rsp_outcome_ff;
   assign rsp_step_count            = rsp_step_count_ff;
   assign rsp_walker_x              = pos_out(rsp_x_ff);
   assign rsp_walker_y              = pos_out(rsp_y_ff);
   assign rsp_escapes               = esc_tally_ff;
   assign rsp_dead_ends             = dead_tally_ff;
   assign rsp_escape_length_total   = esc_sum_ff;
   assign rsp_dead_end_length_total = dead_sum_ff;
   assign rsp_trials_done           = trial_tally_ff;

   // checks
   `SAW_NEXT(a_trial_count, clock, reset, fin_commit && trial_end, trial_tally_ff == $past(trial_tally_ff) + 20'd1, "trial end did not count one trial")
   `SAW_NEXT(a_no_change, clock, reset, fin_commit && (kind_ff == saw_pkg::OUT_BLOCKED || kind_ff == saw_pkg::OUT_FINISHED), $stable(walk_len_ff) && $stable(pos_x_ff) && $stable(pos_y_ff), "blocked or finished item changed the walk")
   `SAW_HOLDS(a_epoch_live, clock, reset, epoch_ff != '0, "trial mark fell to the cleared value")
   `SAW_IMPLIES(a_escape_len, clock, reset, rsp_valid_ff && rsp_outcome_ff == saw_pkg::OUT_ESCAPED, rsp_step_count_ff != '0, "escape reported with zero length")
   `SAW_IMPLIES(a_pos_inside, clock, reset, state_ff == S_IDLE, pos_x_ff != '0 && pos_y_ff != '0, "walker rests on an outside cell")

endmodule

`default_nettype wire

// ===== rtl/saw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; holds the visited map of the walk-step block.
`timescale 1ns / 1ps
`default_nettype none

module saw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sim/tb_self_avoiding_walk_step.sv =====
// Self-checking testbench for the self-avoiding walk step engine.
// Depends on saw_pkg and self_avoiding_walk_step; a built-in walk predictor
// checks every result item field by field.
`timescale 1ns / 1ps

module tb_self_avoiding_walk_step;

   localparam int MAP_SIDE = 128;
   localparam int unsigned STEP_MAX = 16383;
   localparam int unsigned TALLY_MAX = 32'hFFFF_FFFF;
   localparam longint unsigned SUM_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [saw_pkg::TRIALS_W-1:0] LIMIT_MAX = '1;
   // settle time after the last result: longest move plus the centre mark
   localparam int IDLE_SETTLE = 12;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT = 600_000;

   typedef struct packed {
      logic [saw_pkg::OUTCOME_W-1:0] outcome;
      logic [saw_pkg::LEN_W-1:0]     step_count;
      logic [saw_pkg::POS_OUT_W-1:0] walker_x;
      logic [saw_pkg::POS_OUT_W-1:0] walker_y;
      logic [saw_pkg::TALLY_W-1:0]   escapes;
      logic [saw_pkg::TALLY_W-1:0]   dead_ends;
      logic [saw_pkg::SUM_W-1:0]     escape_total;
      logic [saw_pkg::SUM_W-1:0]     dead_end_total;
      logic [saw_pkg::TRIALS_W-1:0]  trials_done;
   } walk_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [saw_pkg::DIR_W-1:0] req_direction = saw_pkg::DIR_PLUS_X;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [saw_pkg::OUTCOME_W-1:0] rsp_outcome;
   logic [saw_pkg::LEN_W-1:0] rsp_step_count;
   logic [saw_pkg::POS_OUT_W-1:0] rsp_walker_x;
   logic [saw_pkg::POS_OUT_W-1:0] rsp_walker_y;
   logic [saw_pkg::TALLY_W-1:0] rsp_escapes;
   logic [saw_pkg::TALLY_W-1:0] rsp_dead_ends;
   logic [saw_pkg::SUM_W-1:0] rsp_escape_length_total;
   logic [saw_pkg::SUM_W-1:0] rsp_dead_end_length_total;
   logic [saw_pkg::TRIALS_W-1:0] rsp_trials_done;
   logic csr_wr_en = 1'b0;
   logic [saw_pkg::CSR_IDX_W-1:0] csr_index = saw_pkg::REG_GRID_SIZE;
   logic [saw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   self_avoiding_walk_step dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_direction            (req_direction),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_outcome              (rsp_outcome),
      .rsp_step_count           (rsp_step_count),
      .rsp_walker_x             (rsp_walker_x),
      .rsp_walker_y             (rsp_walker_y),
      .rsp_escapes              (rsp_escapes),
      .rsp_dead_ends            (rsp_dead_ends),
      .rsp_escape_length_total  (rsp_escape_length_total),
      .rsp_dead_end_length_total(rsp_dead_end_length_total),
      .rsp_trials_done          (rsp_trials_done),
      .csr_wr_en                (csr_wr_en),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------
   // Walk predictor: register copies, walker state and statistics
   // ---------------------------------------------------------------
   logic [saw_pkg::GRID_W-1:0]   grid_cfg;
   logic [saw_pkg::TRIALS_W-1:0] limit_cfg;
   int unsigned walker_col, walker_row, walk_len;
   int unsigned escape_count, dead_end_count, trial_count;
   longint unsigned escape_len_sum, dead_end_len_sum;
   // a cell is visited when it carries the id of the trial in progress
   int unsigned cell_trial [MAP_SIDE*MAP_SIDE];
   int unsigned trial_id;

   walk_result_type expected_results [$];
   logic [saw_pkg::DIR_W-1:0] pending_dirs [$];
   int mismatch_count = 0;
   int results_seen = 0;
   int cycle_count = 0;

   function automatic int unsigned grid_streets();
      if (grid_cfg < 2) return 2;
      if (grid_cfg > MAP_SIDE - 2) return MAP_SIDE - 2;
      return 32'(grid_cfg);
   endfunction

   function automatic bit cell_visited(int unsigned col, int unsigned row);
      if (col >= MAP_SIDE || row >= MAP_SIDE) return 1'b1;
      return cell_trial[col*MAP_SIDE + row] == trial_id;
   endfunction

   function automatic longint unsigned add_length(longint unsigned total, int unsigned len);
      longint unsigned sum;
      sum = total + len;
      return (sum > SUM_MAX) ? SUM_MAX : sum;
   endfunction

   function automatic logic [saw_pkg::DIR_W-1:0] reverse_of(logic [saw_pkg::DIR_W-1:0] dir);
      case (dir)
         saw_pkg::DIR_PLUS_X:  return saw_pkg::DIR_MINUS_X;
         saw_pkg::DIR_MINUS_X: return saw_pkg::DIR_PLUS_X;
         saw_pkg::DIR_PLUS_Y:  return saw_pkg::DIR_MINUS_Y;
         default:              return saw_pkg::DIR_PLUS_Y;
      endcase
   endfunction

   // take a new trial id, so no cell but the centre counts as visited, and put the walker back on the centre
   task automatic begin_trial();
      int unsigned centre;
      centre = (grid_streets() + 1) / 2;
      trial_id++;
      walker_col = centre;
      walker_row = centre;
      walk_len = 0;
      cell_trial[centre*MAP_SIDE + centre] = trial_id;
   endtask

   task automatic reset_walk_model();
      grid_cfg = saw_pkg::GRID_RESET;
      limit_cfg = saw_pkg::LIMIT_RESET;
      escape_count = 0;
      dead_end_count = 0;
      escape_len_sum = 0;
      dead_end_len_sum = 0;
      trial_count = 0;
      trial_id = 0;
      foreach (cell_trial[i]) cell_trial[i] = 0;
      begin_trial();
   endtask

   // advance the walk by one proposed step and queue the expected result
   task automatic predict_walk_step(input logic [saw_pkg::DIR_W-1:0] dir);
      walk_result_type want;
      logic [saw_pkg::OUTCOME_W-1:0] outcome;
      int unsigned next_col, next_row, streets, recorded;
      streets = grid_streets();
      if (trial_count >= limit_cfg) begin
         outcome = saw_pkg::OUT_FINISHED;
         recorded = walk_len;
      end else begin
         next_col = walker_col;
         next_row = walker_row;
         case (dir)
            saw_pkg::DIR_PLUS_X:  next_col = walker_col + 1;
            saw_pkg::DIR_MINUS_X: next_col = walker_col - 1;
            saw_pkg::DIR_PLUS_Y:  next_row = walker_row + 1;
            default:              next_row = walker_row - 1;
         endcase
         if (cell_visited(next_col, next_row)) begin
            outcome = saw_pkg::OUT_BLOCKED;
            recorded = walk_len;
         end else begin
            walker_col = next_col;
            walker_row = next_row;
            cell_trial[next_col*MAP_SIDE + next_row] = trial_id;
            if (walk_len < STEP_MAX) walk_len++;
            if (next_col > streets || next_row > streets || next_col == 0 || next_row == 0)
            begin
               outcome = saw_pkg::OUT_ESCAPED;
               recorded = walk_len;
               if (escape_count != TALLY_MAX) escape_count++;
               escape_len_sum = add_length(escape_len_sum, recorded);
               trial_count++;
               begin_trial();
            end else if (cell_visited(next_col + 1, next_row) &&
                         cell_visited(next_col - 1, next_row) &&
                         cell_visited(next_col, next_row + 1) &&
                         cell_visited(next_col, next_row - 1)) begin
               outcome = saw_pkg::OUT_DEAD_END;
               recorded = walk_len - 1;
               if (dead_end_count != TALLY_MAX) dead_end_count++;
               dead_end_len_sum = add_length(dead_end_len_sum, recorded);
               trial_count++;
               begin_trial();
            end else begin
               outcome = saw_pkg::OUT_MOVED;
               recorded = walk_len;
            end
         end
      end
      want.outcome        = outcome;
      want.step_count     = recorded[saw_pkg::LEN_W-1:0];
      want.walker_x       = walker_col[saw_pkg::POS_OUT_W-1:0];
      want.walker_y       = walker_row[saw_pkg::POS_OUT_W-1:0];
      want.escapes        = escape_count;
      want.dead_ends      = dead_end_count;
      want.escape_total   = escape_len_sum[saw_pkg::SUM_W-1:0];
      want.dead_end_total = dead_end_len_sum[saw_pkg::SUM_W-1:0];
      want.trials_done    = trial_count[saw_pkg::TRIALS_W-1:0];
      expected_results.push_back(want);
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_walk_result();
      walk_result_type got, want;
      got.outcome        = rsp_outcome;
      got.step_count     = rsp_step_count;
      got.walker_x       = rsp_walker_x;
      got.walker_y       = rsp_walker_y;
      got.escapes        = rsp_escapes;
      got.dead_ends      = rsp_dead_ends;
      got.escape_total   = rsp_escape_length_total;
      got.dead_end_total = rsp_dead_end_length_total;
      got.trials_done    = rsp_trials_done;
      if (expected_results.size() == 0) begin
         note_mismatch("unexpected result, outcome", 64'(got.outcome), '0);
      end else begin
         want = expected_results.pop_front();
         if (got.outcome !== want.outcome)
            note_mismatch("outcome", 64'(got.outcome), 64'(want.outcome));
         if (got.step_count !== want.step_count)
            note_mismatch("step_count", 64'(got.step_count), 64'(want.step_count));
         if (got.walker_x !== want.walker_x)
            note_mismatch("walker_x", 64'(got.walker_x), 64'(want.walker_x));
         if (got.walker_y !== want.walker_y)
            note_mismatch("walker_y", 64'(got.walker_y), 64'(want.walker_y));
         if (got.escapes !== want.escapes)
            note_mismatch("escapes", 64'(got.escapes), 64'(want.escapes));
         if (got.dead_ends !== want.dead_ends)
            note_mismatch("dead_ends", 64'(got.dead_ends), 64'(want.dead_ends));
         if (got.escape_total !== want.escape_total)
            note_mismatch("escape_length_total", 64'(got.escape_total),
                          64'(want.escape_total));
         if (got.dead_end_total !== want.dead_end_total)
            note_mismatch("dead_end_length_total", 64'(got.dead_end_total),
                          64'(want.dead_end_total));
         if (got.trials_done !== want.trials_done)
            note_mismatch("trials_done", 64'(got.trials_done), 64'(want.trials_done));
      end
      results_seen++;
   endtask

   // ---------------------------------------------------------------
   // Driver: send queued directions in bursts with random gaps
   // ---------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin : drive_items
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_walk_step(req_direction);
         // free to change the item once the current one is taken
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_dirs.size() > 0) begin
               req_direction <= pending_dirs.pop_front();
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check accepted results, stall in spans of varying density
   // ---------------------------------------------------------------
   int stall_mode = 0;
   int stall_span = 0;

   always @(posedge clock) begin : collect_results
      if (!reset && rsp_valid && !rsp_stall) check_walk_result();
      if (stall_span == 0) begin
         stall_mode = $urandom_range(0, 4);
         stall_span = $urandom_range(20, 200);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         0, 1:    rsp_stall <= 1'b0;
         2:       rsp_stall <= ($urandom_range(0, 3) == 0);
         3:       rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // give up on a hung run
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   // wait for all results, let the block finish its trial bookkeeping
   task automatic wait_until_idle();
      while (pending_dirs.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input logic [saw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [saw_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == saw_pkg::REG_GRID_SIZE) grid_cfg = value[saw_pkg::GRID_W-1:0];
      else limit_cfg = value[saw_pkg::TRIALS_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // grid writes carry junk in the unused upper bits
   task automatic write_grid(input logic [saw_pkg::GRID_W-1:0] streets);
      logic [saw_pkg::CSR_DATA_W-1:0] value;
      int unsigned rnd;
      rnd = $urandom();
      value = rnd[saw_pkg::CSR_DATA_W-1:0];
      value[saw_pkg::GRID_W-1:0] = streets;
      write_reg(saw_pkg::REG_GRID_SIZE, value);
   endtask

   initial begin : stimulus
      logic [saw_pkg::DIR_W-1:0] dead_end_path [8];
      logic [saw_pkg::DIR_W-1:0] escape_blocked [4];
      logic [saw_pkg::DIR_W-1:0] all_dirs [4];
      logic [saw_pkg::GRID_W-1:0] phase_grids [12];
      logic [saw_pkg::DIR_W-1:0] last_dir;
      logic [saw_pkg::TRIALS_W-1:0] limit;
      int unsigned rnd;
      int count;

      dead_end_path = '{saw_pkg::DIR_PLUS_X, saw_pkg::DIR_PLUS_X,
                        saw_pkg::DIR_PLUS_Y, saw_pkg::DIR_PLUS_Y,
                        saw_pkg::DIR_MINUS_X, saw_pkg::DIR_MINUS_X,
                        saw_pkg::DIR_MINUS_Y, saw_pkg::DIR_PLUS_X};
      escape_blocked = '{saw_pkg::DIR_MINUS_Y, saw_pkg::DIR_MINUS_Y,
                         saw_pkg::DIR_PLUS_X, saw_pkg::DIR_MINUS_X};
      all_dirs = '{saw_pkg::DIR_PLUS_X, saw_pkg::DIR_MINUS_X,
                   saw_pkg::DIR_PLUS_Y, saw_pkg::DIR_MINUS_Y};
      phase_grids = '{7'd127, 7'd2, 7'd1, 7'd3, 7'd4, 7'd6,
                      7'd10, 7'd20, 7'd50, 7'd126, 7'd0, 7'd5};

      reset_walk_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one move, then a step back onto the start
      pending_dirs.push_back(saw_pkg::DIR_PLUS_X);
      pending_dirs.push_back(saw_pkg::DIR_MINUS_X);
      wait_until_idle();

      // shrink the grid under the walker: the next move escapes
      write_grid(7'd4);
      write_reg(saw_pkg::REG_TRIAL_LIMIT, LIMIT_MAX);
      pending_dirs.push_back(saw_pkg::DIR_PLUS_Y);
      // spiral into a cell boxed in on all four sides
      foreach (dead_end_path[i]) pending_dirs.push_back(dead_end_path[i]);
      // walk off the low edge, then a blocked step back
      foreach (escape_blocked[i]) pending_dirs.push_back(escape_blocked[i]);
      wait_until_idle();

      // trial limit already reached, then a limit of zero
      write_reg(saw_pkg::REG_TRIAL_LIMIT, 20'd1);
      foreach (all_dirs[i]) pending_dirs.push_back(all_dirs[i]);
      wait_until_idle();
      write_reg(saw_pkg::REG_TRIAL_LIMIT, '0);
      pending_dirs.push_back(saw_pkg::DIR_PLUS_Y);
      wait_until_idle();

      // grid size below range, walker left outside the new grid
      write_grid(7'd0);
      write_reg(saw_pkg::REG_TRIAL_LIMIT, LIMIT_MAX);
      pending_dirs.push_back(saw_pkg::DIR_PLUS_Y);
      pending_dirs.push_back(saw_pkg::DIR_MINUS_X);
      wait_until_idle();

      // random walks over a range of grid sizes and trial limits
      last_dir = saw_pkg::DIR_PLUS_X;
      foreach (phase_grids[p]) begin
         write_grid(phase_grids[p]);
         if (p == 4) rnd = trial_count + 8;
         else if (p % 3 == 0) rnd = $urandom_range(trial_count + 50, LIMIT_MAX);
         else rnd = LIMIT_MAX;
         limit = rnd[saw_pkg::TRIALS_W-1:0];
         write_reg(saw_pkg::REG_TRIAL_LIMIT, limit);
         count = $urandom_range(90, 140);
         repeat (count) begin
            // mostly fresh directions, some immediate reversals
            if ($urandom_range(0, 4) == 0) begin
               last_dir = reverse_of(last_dir);
            end else begin
               rnd = $urandom_range(0, 3);
               last_dir = rnd[saw_pkg::DIR_W-1:0];
            end
            pending_dirs.push_back(last_dir);
         end
         wait_until_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
